>>> rtl/calendar_clock_top_defines.svh
// Assertion macros shared by the calendar clock RTL.
// Included by calclk_dp.sv and calclk_ctrl.sv; needs nothing else.
`ifndef CALENDAR_CLOCK_TOP_DEFINES_SVH
`define CALENDAR_CLOCK_TOP_DEFINES_SVH

`ifndef SYNTHESIS
// Property that must hold at every clock edge outside reset.
`define CC_ASSERT_ALWAYS(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Same-cycle implication.
`define CC_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
// Next-cycle implication.
`define CC_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define CC_ASSERT_ALWAYS(label, clk, rst_n, prop, msg)
`define CC_ASSERT_IMP(label, clk, rst_n, ante, cons, msg)
`define CC_ASSERT_NXT(label, clk, rst_n, ante, cons, msg)
`endif

`endif

>>> rtl/calclk_pkg.sv
// Types, codes and calendar helper functions for the calendar clock.
// Used by calclk_dp, calclk_ctrl and calendar_clock_top; depends on nothing.
`default_nettype none

package calclk_pkg;

  // Width of the carry stage's dividend and quotient.
  localparam int unsigned DIV_W = 17;

  // Action codes.
  localparam logic [1:0] ACT_TICK = 2'd0;
  localparam logic [1:0] ACT_SET  = 2'd1;
  localparam logic [1:0] ACT_ADD  = 2'd2;

  // Unit codes for an add.
  localparam logic [2:0] UNIT_SEC  = 3'd0;
  localparam logic [2:0] UNIT_MIN  = 3'd1;
  localparam logic [2:0] UNIT_HOUR = 3'd2;
  localparam logic [2:0] UNIT_DAY  = 3'd3;
  localparam logic [2:0] UNIT_MON  = 3'd4;
  localparam logic [2:0] UNIT_YEAR = 3'd5;

  // Status codes.
  localparam logic [1:0] STAT_OK     = 2'd0;
  localparam logic [1:0] STAT_REJECT = 2'd1;
  localparam logic [1:0] STAT_SAT    = 2'd2;

  // Carry divisors.
  localparam logic [5:0] SEC_PER_MIN  = 6'd60;
  localparam logic [5:0] MIN_PER_HOUR = 6'd60;
  localparam logic [5:0] HOUR_PER_DAY = 6'd24;
  localparam logic [5:0] MON_PER_YEAR = 6'd12;

  // Reciprocals for the carry quotient: ceil(2^23 / 60), ceil(2^22 / 24) and
  // ceil(2^21 / 12). Each is exact for every 17-bit dividend.
  localparam logic [17:0] RECIP_60 = 18'd139811;
  localparam logic [17:0] RECIP_24 = 18'd174763;
  localparam logic [17:0] RECIP_12 = 18'd174763;

  // Field limits.
  localparam logic [3:0] MONTH_FIRST = 4'd1;
  localparam logic [3:0] MONTH_LAST  = 4'd12;
  localparam logic [4:0] DAY_MAX     = 5'd31;
  localparam logic [4:0] HOUR_LAST   = 5'd23;
  localparam logic [5:0] MIN_LAST    = 6'd59;
  localparam logic [5:0] SEC_LAST    = 6'd59;

  // Year offsets (from 1970) of the century years 2100 and 2200, which are not leap.
  localparam logic [7:0] YOFF_2100 = 8'd130;
  localparam logic [7:0] YOFF_2200 = 8'd230;

  typedef struct packed {
    logic [1:0]  action;
    logic [2:0]  unit;
    logic [15:0] amount;
    logic [7:0]  set_year;
    logic [3:0]  set_month;
    logic [4:0]  set_day;
    logic [4:0]  set_hour;
    logic [5:0]  set_minute;
    logic [5:0]  set_second;
  } calclk_in_t;

  typedef struct packed {
    logic [7:0] year_now;
    logic [3:0] month_now;
    logic [4:0] day_now;
    logic [4:0] hour_now;
    logic [5:0] minute_now;
    logic [5:0] second_now;
    logic [1:0] status;
  } calclk_out_t;

  // Datapath commands.
  typedef enum logic [3:0] {
    CMD_NONE,
    CMD_LOAD,
    CMD_DIV_INIT,
    CMD_DIV_STEP,
    CMD_DIV_END,
    CMD_DAY_INIT,
    CMD_DAY_STEP,
    CMD_ADD_YEAR,
    CMD_SET,
    CMD_REJECT
  } calclk_cmd_e;

  // Which field the carry stage works on.
  typedef enum logic [1:0] {
    SEL_SEC,
    SEL_MIN,
    SEL_HOUR,
    SEL_MON
  } calclk_sel_e;

  typedef struct packed {
    calclk_cmd_e cmd;
    calclk_sel_e sel;
  } calclk_ctl_t;

  typedef struct packed {
    logic [1:0] action;
    logic [2:0] unit;
    logic       day_last;
  } calclk_sts_t;

  // Gregorian leap test on a year offset from 1970. Within offsets 0..255 the
  // year is a multiple of four when the offset is 2 mod 4; of the century
  // years in range only 2000 is leap.
  function automatic logic is_leap(input logic [7:0] yoff);
    return (yoff[1:0] == 2'd2) && (yoff != YOFF_2100) && (yoff != YOFF_2200);
  endfunction

  // Number of days in a month.
  function automatic logic [4:0] month_len(input logic [3:0] month, input logic leap);
    logic [4:0] len;
    case (month) inside
      4'd4, 4'd6, 4'd9, 4'd11: len = 5'd30;
      4'd2:                    len = leap ? 5'd29 : 5'd28;
      default:                 len = DAY_MAX;
    endcase
    return len;
  endfunction

endpackage

`default_nettype wire

>>> rtl/calendar_clock_top.sv
// Calendar clock: a set, a year add or a rejected item is done at dispatch; a month add runs
// the carry stage once; a tick or a second add runs it for seconds, minutes and hours and then
// the month walk (a minute add starts at minutes, an hour add at hours, a day add at the walk).
// One item at a time, the next beat taken the cycle after the result beat. The carry stage
// runs init, quotient step and write-back per unit. Reset (asynchronous, active low)
// returns the time to offset 0, January 1, 00:00:00. Uses calclk_pkg, calclk_dp, calclk_ctrl.
`default_nettype none

module calendar_clock_top #(
  parameter int YEAR_LIMIT  = 255,
  parameter int AMOUNT_BITS = 16
) (
  input  wire                      clk_i,
  input  wire                      rst_ni,
  input  wire                      in_valid_i,
  output logic                     in_stall_o,
  input  calclk_pkg::calclk_in_t   in_data_i,
  output logic                     out_valid_o,
  input  wire                      out_stall_i,
  output calclk_pkg::calclk_out_t  out_data_o
);

  calclk_pkg::calclk_ctl_t ctl;
  calclk_pkg::calclk_sts_t sts;

  // Sequencer.
  calclk_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .sts_i       (sts),
    .ctl_o       (ctl)
  );

  // Time registers and arithmetic.
  calclk_dp #(
    .YEAR_LIMIT  (YEAR_LIMIT),
    .AMOUNT_BITS (AMOUNT_BITS)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_data_i  (in_data_i),
    .ctl_i      (ctl),
    .sts_o      (sts),
    .out_data_o (out_data_o)
  );

endmodule

`default_nettype wire

>>> rtl/calclk_dp.sv
// Datapath of the calendar clock: time registers, carry stage, month walk.
// Uses calclk_pkg and calendar_clock_top_defines.svh; driven by calclk_ctrl.
`default_nettype none
`include "calendar_clock_top_defines.svh"

module calclk_dp #(
  parameter int YEAR_LIMIT  = 255,
  parameter int AMOUNT_BITS = 16
) (
  input  wire                      clk_i,
  input  wire                      rst_ni,
  input  calclk_pkg::calclk_in_t   in_data_i,
  input  calclk_pkg::calclk_ctl_t  ctl_i,
  output calclk_pkg::calclk_sts_t  sts_o,
  output calclk_pkg::calclk_out_t  out_data_o
);

  localparam int unsigned DivW = calclk_pkg::DIV_W;
  localparam logic [7:0] YearMax = 8'(YEAR_LIMIT);
  localparam logic [15:0] AmtMask =
    (AMOUNT_BITS >= 16) ? 16'hFFFF : 16'((32'd1 << AMOUNT_BITS) - 32'd1);

  // Time state.
  logic [7:0] year_q, year_d;
  logic [3:0] month_q, month_d;
  logic [4:0] day_q, day_d;
  logic [4:0] hour_q, hour_d;
  logic [5:0] minute_q, minute_d;
  logic [5:0] second_q, second_d;
  logic [1:0] status_q, status_d;

  // Working registers.
  calclk_pkg::calclk_in_t item_q, item_d;
  logic [DivW-1:0] work_q, work_d;
  logic [DivW-1:0] quo_q, quo_d;

  logic [15:0]     amount_m;
  logic [5:0]      divisor;
  logic [17:0]     recip;
  logic [DivW-1:0] field_ext;
  logic [DivW-1:0] div_init_val;
  logic [34:0]     recip_prod;
  logic [DivW-1:0] quo_est;
  logic [DivW-1:0] div_prod;
  logic [DivW-1:0] div_diff;
  logic [5:0]      div_rem;
  logic [4:0]      cur_len;
  logic            at_year_end;
  logic            at_limit;
  logic            walk_fit;
  logic [DivW:0]   mon_year;
  logic            mon_sat;
  logic [3:0]      mon_new;
  logic [4:0]      mon_len;
  logic [DivW-1:0] yr_sum;
  logic            yr_sat;
  logic [4:0]      yr_len;
  logic [4:0]      set_len;
  logic            set_ok;
  logic            sat_req;

  assign amount_m = item_q.amount & AmtMask;

  // Divisor, reciprocal and dividend selection for the carry stage.
  always_comb begin
    case (ctl_i.sel)
      calclk_pkg::SEL_SEC: begin
        divisor   = calclk_pkg::SEC_PER_MIN;
        recip     = calclk_pkg::RECIP_60;
        field_ext = {11'b0, second_q};
      end
      calclk_pkg::SEL_MIN: begin
        divisor   = calclk_pkg::MIN_PER_HOUR;
        recip     = calclk_pkg::RECIP_60;
        field_ext = {11'b0, minute_q};
      end
      calclk_pkg::SEL_HOUR: begin
        divisor   = calclk_pkg::HOUR_PER_DAY;
        recip     = calclk_pkg::RECIP_24;
        field_ext = {12'b0, hour_q};
      end
      default: begin
        divisor   = calclk_pkg::MON_PER_YEAR;
        recip     = calclk_pkg::RECIP_12;
        field_ext = {13'b0, month_q - calclk_pkg::MONTH_FIRST};
      end
    endcase
  end

  assign div_init_val = field_ext + work_q;

  // Quotient of the dividend in work_q by reciprocal multiplication.
  assign recip_prod = {18'b0, work_q} * {17'b0, recip};

  always_comb begin
    case (ctl_i.sel)
      calclk_pkg::SEL_SEC:  quo_est = {5'b0, recip_prod[34:23]};
      calclk_pkg::SEL_MIN:  quo_est = {5'b0, recip_prod[34:23]};
      calclk_pkg::SEL_HOUR: quo_est = {4'b0, recip_prod[34:22]};
      default:              quo_est = {3'b0, recip_prod[34:21]};
    endcase
  end

  // Remainder from the registered quotient; it always fits in six bits.
  assign div_prod = quo_q * {11'b0, divisor};
  assign div_diff = work_q - div_prod;
  assign div_rem  = div_diff[5:0];

  // Month walk: one month is taken off the remaining day count per step.
  assign cur_len     = calclk_pkg::month_len(month_q, calclk_pkg::is_leap(year_q));
  assign at_year_end = (month_q == calclk_pkg::MONTH_LAST);
  assign at_limit    = (year_q >= YearMax);
  assign walk_fit    = (work_q <= {12'b0, cur_len});

  // Month add: the carry stage leaves whole years in quo_q and the month index in div_rem.
  assign mon_year = {10'b0, year_q} + {1'b0, quo_q};
  assign mon_sat  = mon_year > (DivW+1)'(YEAR_LIMIT);
  assign mon_new  = div_rem[3:0] + calclk_pkg::MONTH_FIRST;
  assign mon_len  = calclk_pkg::month_len(mon_new, calclk_pkg::is_leap(mon_year[7:0]));

  // Year add.
  assign yr_sum = {9'b0, year_q} + {1'b0, amount_m};
  assign yr_sat = yr_sum > DivW'(YEAR_LIMIT);
  assign yr_len = calclk_pkg::month_len(month_q, calclk_pkg::is_leap(yr_sum[7:0]));

  // Field check for a set.
  assign set_len = calclk_pkg::month_len(item_q.set_month,
                                         calclk_pkg::is_leap(item_q.set_year));
  assign set_ok  = (item_q.set_year <= YearMax) &&
                   (item_q.set_month != 4'd0) &&
                   (item_q.set_month <= calclk_pkg::MONTH_LAST) &&
                   (item_q.set_day != 5'd0) &&
                   (item_q.set_day <= set_len) &&
                   (item_q.set_hour <= calclk_pkg::HOUR_LAST) &&
                   (item_q.set_minute <= calclk_pkg::MIN_LAST) &&
                   (item_q.set_second <= calclk_pkg::SEC_LAST);

  // Command decode.
  always_comb begin
    year_d   = year_q;
    month_d  = month_q;
    day_d    = day_q;
    hour_d   = hour_q;
    minute_d = minute_q;
    second_d = second_q;
    status_d = status_q;
    item_d   = item_q;
    work_d   = work_q;
    quo_d    = quo_q;
    sat_req  = 1'b0;

    unique case (ctl_i.cmd)
      calclk_pkg::CMD_LOAD: begin
        item_d   = in_data_i;
        status_d = calclk_pkg::STAT_OK;
        if (in_data_i.action == calclk_pkg::ACT_TICK) begin
          work_d = DivW'(1);
        end else begin
          work_d = {1'b0, in_data_i.amount & AmtMask};
        end
      end
      calclk_pkg::CMD_DIV_INIT: begin
        work_d = div_init_val;
      end
      calclk_pkg::CMD_DIV_STEP: begin
        quo_d = quo_est;
      end
      calclk_pkg::CMD_DIV_END: begin
        work_d = quo_q;
        case (ctl_i.sel)
          calclk_pkg::SEL_SEC:  second_d = div_rem;
          calclk_pkg::SEL_MIN:  minute_d = div_rem;
          calclk_pkg::SEL_HOUR: hour_d   = div_rem[4:0];
          default: begin
            if (mon_sat) begin
              sat_req = 1'b1;
            end else begin
              year_d  = mon_year[7:0];
              month_d = mon_new;
              if (day_q > mon_len) begin
                day_d = mon_len;
              end
            end
          end
        endcase
      end
      calclk_pkg::CMD_DAY_INIT: begin
        work_d = {12'b0, day_q} + work_q;
      end
      calclk_pkg::CMD_DAY_STEP: begin
        if (walk_fit) begin
          day_d = work_q[4:0];
        end else if (at_year_end) begin
          if (at_limit) begin
            sat_req = 1'b1;
          end else begin
            year_d  = year_q + 8'd1;
            month_d = calclk_pkg::MONTH_FIRST;
            work_d  = work_q - {12'b0, cur_len};
          end
        end else begin
          month_d = month_q + 4'd1;
          work_d  = work_q - {12'b0, cur_len};
        end
      end
      calclk_pkg::CMD_ADD_YEAR: begin
        if (yr_sat) begin
          sat_req = 1'b1;
        end else begin
          year_d = yr_sum[7:0];
          if (day_q > yr_len) begin
            day_d = yr_len;
          end
        end
      end
      calclk_pkg::CMD_SET: begin
        if (set_ok) begin
          year_d   = item_q.set_year;
          month_d  = item_q.set_month;
          day_d    = item_q.set_day;
          hour_d   = item_q.set_hour;
          minute_d = item_q.set_minute;
          second_d = item_q.set_second;
        end else begin
          status_d = calclk_pkg::STAT_REJECT;
        end
      end
      calclk_pkg::CMD_REJECT: begin
        status_d = calclk_pkg::STAT_REJECT;
      end
      default: begin
      end
    endcase

    // Past the last second of the last year: pin to the end and flag it.
    if (sat_req) begin
      year_d   = YearMax;
      month_d  = calclk_pkg::MONTH_LAST;
      day_d    = calclk_pkg::DAY_MAX;
      hour_d   = calclk_pkg::HOUR_LAST;
      minute_d = calclk_pkg::MIN_LAST;
      second_d = calclk_pkg::SEC_LAST;
      status_d = calclk_pkg::STAT_SAT;
    end
  end

  // Time state registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      year_q   <= 8'd0;
      month_q  <= calclk_pkg::MONTH_FIRST;
      day_q    <= 5'd1;
      hour_q   <= 5'd0;
      minute_q <= 6'd0;
      second_q <= 6'd0;
      status_q <= calclk_pkg::STAT_OK;
    end else begin
      year_q   <= year_d;
      month_q  <= month_d;
      day_q    <= day_d;
      hour_q   <= hour_d;
      minute_q <= minute_d;
      second_q <= second_d;
      status_q <= status_d;
    end
  end

  // Working registers carry no reset.
  always_ff @(posedge clk_i) begin
    item_q <= item_d;
    work_q <= work_d;
    quo_q  <= quo_d;
  end

  assign sts_o.action   = item_q.action;
  assign sts_o.unit     = item_q.unit;
  assign sts_o.day_last = walk_fit || (at_year_end && at_limit);

  assign out_data_o.year_now   = year_q;
  assign out_data_o.month_now  = month_q;
  assign out_data_o.day_now    = day_q;
  assign out_data_o.hour_now   = hour_q;
  assign out_data_o.minute_now = minute_q;
  assign out_data_o.second_now = second_q;
  assign out_data_o.status     = status_q;

  // The time fields stay in their calendar ranges through every command.
  `CC_ASSERT_ALWAYS(a_year_range, clk_i, rst_ni, year_q <= YearMax, "year past limit")
  `CC_ASSERT_ALWAYS(a_month_range, clk_i, rst_ni,
    (month_q >= calclk_pkg::MONTH_FIRST) && (month_q <= calclk_pkg::MONTH_LAST),
    "month out of range")
  `CC_ASSERT_ALWAYS(a_day_range, clk_i, rst_ni, day_q != 5'd0, "day is zero")
  `CC_ASSERT_ALWAYS(a_clock_range, clk_i, rst_ni,
    (hour_q <= calclk_pkg::HOUR_LAST) && (minute_q <= calclk_pkg::MIN_LAST) &&
    (second_q <= calclk_pkg::SEC_LAST),
    "clock field out of range")

endmodule

`default_nettype wire

>>> rtl/calclk_ctrl.sv
// Sequencer of the calendar clock: handshakes and datapath command stream.
// Uses calclk_pkg and calendar_clock_top_defines.svh; drives calclk_dp.
`default_nettype none
`include "calendar_clock_top_defines.svh"

module calclk_ctrl (
  input  wire                      clk_i,
  input  wire                      rst_ni,
  input  wire                      in_valid_i,
  output logic                     in_stall_o,
  output logic                     out_valid_o,
  input  wire                      out_stall_i,
  input  calclk_pkg::calclk_sts_t  sts_i,
  output calclk_pkg::calclk_ctl_t  ctl_o
);

  localparam logic [2:0] ST_IDLE     = 3'd0;
  localparam logic [2:0] ST_DISPATCH = 3'd1;
  localparam logic [2:0] ST_DIV_INIT = 3'd2;
  localparam logic [2:0] ST_DIV_RUN  = 3'd3;
  localparam logic [2:0] ST_DIV_END  = 3'd4;
  localparam logic [2:0] ST_DAY_INIT = 3'd5;
  localparam logic [2:0] ST_DAY_WALK = 3'd6;
  localparam logic [2:0] ST_OUTPUT   = 3'd7;

  logic [2:0]              state_q, state_d;
  calclk_pkg::calclk_sel_e sel_q, sel_d;
  calclk_pkg::calclk_cmd_e cmd;

  // Next state and command.
  always_comb begin
    state_d = state_q;
    sel_d   = sel_q;
    cmd     = calclk_pkg::CMD_NONE;

    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd     = calclk_pkg::CMD_LOAD;
          state_d = ST_DISPATCH;
        end
      end
      ST_DISPATCH: begin
        case (sts_i.action)
          calclk_pkg::ACT_TICK: begin
            sel_d   = calclk_pkg::SEL_SEC;
            state_d = ST_DIV_INIT;
          end
          calclk_pkg::ACT_SET: begin
            cmd     = calclk_pkg::CMD_SET;
            state_d = ST_OUTPUT;
          end
          calclk_pkg::ACT_ADD: begin
            case (sts_i.unit)
              calclk_pkg::UNIT_SEC: begin
                sel_d   = calclk_pkg::SEL_SEC;
                state_d = ST_DIV_INIT;
              end
              calclk_pkg::UNIT_MIN: begin
                sel_d   = calclk_pkg::SEL_MIN;
                state_d = ST_DIV_INIT;
              end
              calclk_pkg::UNIT_HOUR: begin
                sel_d   = calclk_pkg::SEL_HOUR;
                state_d = ST_DIV_INIT;
              end
              calclk_pkg::UNIT_DAY: begin
                state_d = ST_DAY_INIT;
              end
              calclk_pkg::UNIT_MON: begin
                sel_d   = calclk_pkg::SEL_MON;
                state_d = ST_DIV_INIT;
              end
              calclk_pkg::UNIT_YEAR: begin
                cmd     = calclk_pkg::CMD_ADD_YEAR;
                state_d = ST_OUTPUT;
              end
              default: begin
                cmd     = calclk_pkg::CMD_REJECT;
                state_d = ST_OUTPUT;
              end
            endcase
          end
          default: begin
            cmd     = calclk_pkg::CMD_REJECT;
            state_d = ST_OUTPUT;
          end
        endcase
      end
      ST_DIV_INIT: begin
        cmd     = calclk_pkg::CMD_DIV_INIT;
        state_d = ST_DIV_RUN;
      end
      ST_DIV_RUN: begin
        // The quotient takes a single reciprocal step.
        cmd     = calclk_pkg::CMD_DIV_STEP;
        state_d = ST_DIV_END;
      end
      ST_DIV_END: begin
        cmd = calclk_pkg::CMD_DIV_END;
        // Carry moves up to the next larger unit.
        case (sel_q)
          calclk_pkg::SEL_SEC: begin
            sel_d   = calclk_pkg::SEL_MIN;
            state_d = ST_DIV_INIT;
          end
          calclk_pkg::SEL_MIN: begin
            sel_d   = calclk_pkg::SEL_HOUR;
            state_d = ST_DIV_INIT;
          end
          calclk_pkg::SEL_HOUR: begin
            state_d = ST_DAY_INIT;
          end
          default: begin
            state_d = ST_OUTPUT;
          end
        endcase
      end
      ST_DAY_INIT: begin
        cmd     = calclk_pkg::CMD_DAY_INIT;
        state_d = ST_DAY_WALK;
      end
      ST_DAY_WALK: begin
        cmd = calclk_pkg::CMD_DAY_STEP;
        if (sts_i.day_last) begin
          state_d = ST_OUTPUT;
        end
      end
      ST_OUTPUT: begin
        if (!out_stall_i) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      sel_q   <= calclk_pkg::SEL_SEC;
    end else begin
      state_q <= state_d;
      sel_q   <= sel_d;
    end
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = (state_q == ST_OUTPUT);
  assign ctl_o.cmd   = cmd;
  assign ctl_o.sel   = sel_q;

  // An accepted beat is always followed by dispatch.
  `CC_ASSERT_NXT(a_accept_dispatch, clk_i, rst_ni, in_valid_i && !in_stall_o,
    state_q == ST_DISPATCH, "accepted beat not dispatched")
  // A result is never offered while a new item can be taken.
  `CC_ASSERT_IMP(a_no_overlap, clk_i, rst_ni, !in_stall_o, !out_valid_o,
    "result offered while idle")
  // Once the result beat is taken the block is free again.
  `CC_ASSERT_NXT(a_release, clk_i, rst_ni, out_valid_o && !out_stall_i, !in_stall_o,
    "block busy after result taken")
  // The quotient step is always followed by the carry write-back.
  `CC_ASSERT_NXT(a_div_step, clk_i, rst_ni, state_q == ST_DIV_RUN, state_q == ST_DIV_END,
    "carry stage did not finish")

endmodule

`default_nettype wire
